// ===== hdl/cild_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cild_pkg: shared types and constants of the colour line walker
// Holds the payload structs, the queue entry and the fixed-point sizes.
// ----------------------------------------------------------------------------
package cild_pkg;

	localparam int CoordW = 6;
	localparam int ColW = 8;
	localparam int FracW = 8;
	// colour accumulator: sign, headroom and fraction
	localparam int AccW = ColW + FracW + 2;
	// numerator of the colour step: signed difference times the fraction scale
	localparam int NumW = ColW + FracW + 1;

	typedef struct packed {
		logic [CoordW-1:0] start_x;
		logic [CoordW-1:0] start_y;
		logic [CoordW-1:0] end_x;
		logic [CoordW-1:0] end_y;
		logic [ColW-1:0] start_red;
		logic [ColW-1:0] start_green;
		logic [ColW-1:0] start_blue;
		logic [ColW-1:0] end_red;
		logic [ColW-1:0] end_green;
		logic [ColW-1:0] end_blue;
	} line_in_t;

	typedef struct packed {
		logic [CoordW-1:0] pixel_x;
		logic [CoordW-1:0] pixel_y;
		logic [ColW-1:0] pixel_red;
		logic [ColW-1:0] pixel_green;
		logic [ColW-1:0] pixel_blue;
		logic last_pixel;
	} pixel_out_t;

	// classified line, ordered so the major coordinate rises
	typedef struct packed {
		logic xmajor;
		logic [CoordW-1:0] maj0;
		logic [CoordW-1:0] min0;
		logic [CoordW-1:0] len;
		logic [CoordW-1:0] mlen;
		logic minor_down;
		logic [2:0][ColW-1:0] c0;
		logic [2:0][ColW-1:0] c1;
	} line_cmd_t;

endpackage

// ===== hdl/color_interpolated_line_draw_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_interpolated_line_draw_unit: colour-interpolated midpoint line walker
// A line is taken when start is high and busy low. It lands in a one-entry
// queue, and busy is high only while that entry holds a line the walker has
// not yet taken, so a new line can be queued while the walker is drawing. The
// walker takes the queued line once it is idle, divides the colour steps
// serially, then emits one pixel per cycle, len pixels in all. A line
// waiting in the queue is taken as soon as the walker returns to idle.
// Results are strobed for one cycle and cannot be stalled. Lines of zero
// length are dropped.
// ----------------------------------------------------------------------------
module color_interpolated_line_draw_unit import cild_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  line_in_t   line_in,
	output pixel_out_t pixel,
	output logic       pixel_strobe
);

	line_cmd_t cmd_c, qcmd_q;
	logic cmd_ok, full_q, take;

	cild_front u_front (.line_in(line_in), .cmd(cmd_c), .cmd_valid(cmd_ok));

	assign busy = full_q;

	// one-entry queue between classifier and walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else begin
			if (start && !full_q && cmd_ok) full_q <= 1'b1;
			else if (take) full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !full_q) qcmd_q <= cmd_c;
	end

	cild_back u_back (.clk(clk), .arst_n(arst_n), .cmd(qcmd_q), .cmd_valid(full_q),
		.cmd_take(take), .pixel(pixel), .pixel_valid(pixel_strobe));

endmodule

// ===== hdl/cild_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cild_front: line classifier
// Picks the major axis, orders endpoints and flags degenerate lines.
// ----------------------------------------------------------------------------
module cild_front import cild_pkg::*; (
	input  line_in_t  line_in,
	output line_cmd_t cmd,
	output logic      cmd_valid
);

	logic [CoordW:0] dx, dy;
	logic [CoordW-1:0] adx, ady, mj0, mn0, mj1, mn1;
	logic xmaj, swap;

	// compare spans and order endpoints
	always_comb begin
		dx = {1'b0, line_in.end_x} - {1'b0, line_in.start_x};
		dy = {1'b0, line_in.end_y} - {1'b0, line_in.start_y};
		adx = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
		ady = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
		xmaj = ady <= adx;
		mj0 = xmaj ? line_in.start_x : line_in.start_y;
		mn0 = xmaj ? line_in.start_y : line_in.start_x;
		mj1 = xmaj ? line_in.end_x : line_in.end_y;
		mn1 = xmaj ? line_in.end_y : line_in.end_x;
		swap = mj1 < mj0;
		cmd.xmajor = xmaj;
		cmd.maj0 = swap ? mj1 : mj0;
		cmd.min0 = swap ? mn1 : mn0;
		cmd.len = swap ? (mj0 - mj1) : (mj1 - mj0);
		cmd.minor_down = swap ? (mn0 < mn1) : (mn1 < mn0);
		cmd.mlen = xmaj ? ady : adx;
		cmd.c0 = swap ? {line_in.end_blue, line_in.end_green, line_in.end_red}
			: {line_in.start_blue, line_in.start_green, line_in.start_red};
		cmd.c1 = swap ? {line_in.start_blue, line_in.start_green, line_in.start_red}
			: {line_in.end_blue, line_in.end_green, line_in.end_red};
		cmd_valid = cmd.len != '0;
	end

endmodule

// ===== hdl/cild_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cild_back: pixel walker
// Divides the colour steps serially, then emits one pixel per cycle.
// ----------------------------------------------------------------------------
module cild_back import cild_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  line_cmd_t  cmd,
	input  logic       cmd_valid,
	output logic       cmd_take,
	output pixel_out_t pixel,
	output logic       pixel_valid
);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StDiv = 2'd1;
	localparam logic [1:0] StWalk = 2'd2;

	logic [1:0] state_q;
	line_cmd_t line_q;
	logic [4:0] bit_q;
	logic [2:0][NumW-1:0] quo_q;
	logic [2:0][CoordW:0] rem_q;
	logic [2:0] neg_q;
	logic [2:0][AccW-1:0] acc_q;
	logic [CoordW-1:0] k_q, min_q;
	logic signed [CoordW+2:0] d_q;
	logic [2:0][NumW-1:0] mag;
	logic [2:0][CoordW:0] rtry;

	assign cmd_take = state_q == StIdle && cmd_valid;

	// magnitude of each colour difference, scaled
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = (cmd.c1[i] >= cmd.c0[i])
				? NumW'({cmd.c1[i] - cmd.c0[i], {FracW{1'b0}}})
				: NumW'({cmd.c0[i] - cmd.c1[i], {FracW{1'b0}}});
			rtry[i] = {rem_q[i][CoordW-1:0], quo_q[i][NumW-1]};
		end
	end

	// sequence divide and walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			pixel_valid <= 1'b0;
		end else begin
			pixel_valid <= 1'b0;
			case (state_q)
				StIdle: begin
					if (cmd_valid) begin
						state_q <= StDiv;
						bit_q <= 5'(NumW);
						line_q <= cmd;
						for (int i = 0; i < 3; i++) begin
							quo_q[i] <= mag[i];
							rem_q[i] <= '0;
							neg_q[i] <= cmd.c1[i] < cmd.c0[i];
							acc_q[i] <= AccW'({cmd.c0[i], {FracW{1'b0}}});
						end
						k_q <= '0;
						min_q <= cmd.min0;
						d_q <= $signed({2'b0, cmd.mlen, 1'b0}) - $signed({3'b0, cmd.len});
					end
				end
				StDiv: begin
					// one restoring quotient bit per cycle
					for (int i = 0; i < 3; i++) begin
						if (rtry[i] >= {1'b0, line_q.len}) begin
							rem_q[i] <= rtry[i] - {1'b0, line_q.len};
							quo_q[i] <= {quo_q[i][NumW-2:0], 1'b1};
						end else begin
							rem_q[i] <= rtry[i];
							quo_q[i] <= {quo_q[i][NumW-2:0], 1'b0};
						end
					end
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd1) state_q <= StWalk;
				end
				StWalk: begin
					pixel_valid <= 1'b1;
					pixel.pixel_x <= line_q.xmajor ? line_q.maj0 + k_q : min_q;
					pixel.pixel_y <= line_q.xmajor ? min_q : line_q.maj0 + k_q;
					pixel.pixel_red <= acc_q[0][AccW-1] ? '0 : (|acc_q[0][AccW-2:AccW-2]
						? 8'hFF : acc_q[0][FracW+ColW-1:FracW]);
					pixel.pixel_green <= acc_q[1][AccW-1] ? '0 : (|acc_q[1][AccW-2:AccW-2]
						? 8'hFF : acc_q[1][FracW+ColW-1:FracW]);
					pixel.pixel_blue <= acc_q[2][AccW-1] ? '0 : (|acc_q[2][AccW-2:AccW-2]
						? 8'hFF : acc_q[2][FracW+ColW-1:FracW]);
					pixel.last_pixel <= k_q == line_q.len - 1'b1;
					if (d_q > 0) begin
						min_q <= line_q.minor_down ? min_q - 1'b1 : min_q + 1'b1;
						d_q <= d_q + $signed({2'b0, line_q.mlen, 1'b0})
							- $signed({2'b0, line_q.len, 1'b0});
					end else begin
						d_q <= d_q + $signed({2'b0, line_q.mlen, 1'b0});
					end
					for (int i = 0; i < 3; i++)
						acc_q[i] <= neg_q[i] ? acc_q[i] - AccW'(quo_q[i])
							: acc_q[i] + AccW'(quo_q[i]);
					k_q <= k_q + 1'b1;
					if (k_q == line_q.len - 1'b1) state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel.last_pixel |-> state_q == StIdle) else $error("walk overrun");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> state_q == StDiv) else $error("no divide after take");
	a_no_out_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StDiv |=> !pixel_valid || $past(state_q) == StWalk) else $error("early pixel");

endmodule

// ===== tb/color_interpolated_line_draw_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_interpolated_line_draw_unit_tb: self-checking bench of the line walker
// Feeds directed and random lines in bursts, predicts every pixel with a
// midpoint walker of its own and checks each strobed pixel field by field.
// ----------------------------------------------------------------------------
module color_interpolated_line_draw_unit_tb;
	import cild_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	line_in_t line_in;
	pixel_out_t pixel;
	logic pixel_strobe;

	line_in_t pending_lines[$];
	pixel_out_t expected_pixels[$];
	int error_count;
	int gap_left;
	int burst_left;

	color_interpolated_line_draw_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.line_in(line_in),
		.pixel(pixel),
		.pixel_strobe(pixel_strobe)
	);

	// clock: 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// walk one line and queue the pixels it should plot
	function automatic void walk_line(line_in_t l);
		longint x0, y0, x1, y1, dx, dy, maj0, min0, maj1, min1, len, mlen, smin, d, t;
		longint c0[3], c1[3], acc[3], stp[3], ip;
		bit xmajor;
		pixel_out_t p;
		logic [ColW-1:0] col[3];
		x0 = longint'(l.start_x);
		y0 = longint'(l.start_y);
		x1 = longint'(l.end_x);
		y1 = longint'(l.end_y);
		c0[0] = longint'(l.start_red);
		c0[1] = longint'(l.start_green);
		c0[2] = longint'(l.start_blue);
		c1[0] = longint'(l.end_red);
		c1[1] = longint'(l.end_green);
		c1[2] = longint'(l.end_blue);
		dx = x1 - x0;
		dy = y1 - y0;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		xmajor = dy <= dx;
		if (xmajor) begin
			maj0 = x0; min0 = y0; maj1 = x1; min1 = y1;
		end else begin
			maj0 = y0; min0 = x0; maj1 = y1; min1 = x1;
		end
		// order endpoints so the major coordinate rises, colours with them
		if (maj1 < maj0) begin
			t = maj0; maj0 = maj1; maj1 = t;
			t = min0; min0 = min1; min1 = t;
			for (int i = 0; i < 3; i++) begin
				t = c0[i]; c0[i] = c1[i]; c1[i] = t;
			end
		end
		len = maj1 - maj0;
		if (len <= 0) return;
		mlen = min1 - min0;
		smin = mlen < 0 ? -1 : 1;
		if (mlen < 0) mlen = -mlen;
		for (int i = 0; i < 3; i++) begin
			acc[i] = c0[i] * 256;
			// SystemVerilog division truncates toward zero, as wanted
			stp[i] = ((c1[i] - c0[i]) * 256) / len;
		end
		d = 2 * mlen - len;
		for (longint k = 0; k < len; k++) begin
			for (int i = 0; i < 3; i++) begin
				if (acc[i] < 0) ip = 0;
				else ip = acc[i] >>> FracW;
				if (ip > 255) ip = 255;
				col[i] = ip[ColW-1:0];
			end
			p.pixel_x = CoordW'(xmajor ? (maj0 + k) : min0);
			p.pixel_y = CoordW'(xmajor ? min0 : (maj0 + k));
			p.pixel_red = col[0];
			p.pixel_green = col[1];
			p.pixel_blue = col[2];
			p.last_pixel = (k == len - 1);
			expected_pixels.push_back(p);
			if (d > 0) begin
				min0 += smin;
				d -= 2 * len;
			end
			d += 2 * mlen;
			for (int i = 0; i < 3; i++) acc[i] += stp[i];
		end
	endfunction

	function automatic line_in_t make_line(int x0, int y0, int x1, int y1,
			int r0, int g0, int b0, int r1, int g1, int b1);
		line_in_t l;
		l.start_x = CoordW'(x0); l.start_y = CoordW'(y0);
		l.end_x = CoordW'(x1); l.end_y = CoordW'(y1);
		l.start_red = ColW'(r0); l.start_green = ColW'(g0); l.start_blue = ColW'(b0);
		l.end_red = ColW'(r1); l.end_green = ColW'(g1); l.end_blue = ColW'(b1);
		return l;
	endfunction

	function automatic line_in_t random_line();
		line_in_t l;
		int shape;
		logic [95:0] rnd;
		rnd = {$urandom, $urandom, $urandom};
		l = rnd[$bits(line_in_t)-1:0];
		shape = $urandom_range(0, 9);
		// half short lines; some full random, some axis-aligned or diagonal
		if (shape < 5) begin
			l.end_x = CoordW'(int'(l.start_x) + int'($urandom_range(0, 12)) - 6);
			l.end_y = CoordW'(int'(l.start_y) + int'($urandom_range(0, 12)) - 6);
			if (l.start_x < 6 || l.start_x > 57) l.end_x = l.start_x;
			if (l.start_y < 6 || l.start_y > 57) l.end_y = l.start_y;
		end else if (shape == 6) begin
			l.end_x = l.start_x;
		end else if (shape == 7) begin
			l.end_y = l.start_y;
		end else if (shape == 8) begin
			l.end_x = l.start_y;
			l.end_y = l.start_x;
		end
		return l;
	endfunction

	// drive lines in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			line_in <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (!(start && busy)) begin
			// previous transfer accepted (or nothing offered)
			if (start) begin
				walk_line(line_in);
				void'(pending_lines.pop_front());
			end
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_lines.size() > 0) begin
				start <= 1'b1;
				line_in <= pending_lines[0];
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 8);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// check each strobed pixel against the oldest prediction
	always @(posedge clk) begin
		pixel_out_t want;
		if (arst_n && pixel_strobe) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel with none expected: %p", pixel);
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (pixel.pixel_x !== want.pixel_x) begin
					$error("pixel_x expected %0d got %0d", want.pixel_x, pixel.pixel_x);
					error_count++;
				end
				if (pixel.pixel_y !== want.pixel_y) begin
					$error("pixel_y expected %0d got %0d", want.pixel_y, pixel.pixel_y);
					error_count++;
				end
				if (pixel.pixel_red !== want.pixel_red) begin
					$error("pixel_red expected %0d got %0d", want.pixel_red, pixel.pixel_red);
					error_count++;
				end
				if (pixel.pixel_green !== want.pixel_green) begin
					$error("pixel_green expected %0d got %0d", want.pixel_green,
						pixel.pixel_green);
					error_count++;
				end
				if (pixel.pixel_blue !== want.pixel_blue) begin
					$error("pixel_blue expected %0d got %0d", want.pixel_blue, pixel.pixel_blue);
					error_count++;
				end
				if (pixel.last_pixel !== want.last_pixel) begin
					$error("last_pixel expected %0d got %0d", want.last_pixel, pixel.last_pixel);
					error_count++;
				end
			end
		end
	end

	// fill the line queue, then wait for the pixels to drain
	initial begin
		error_count = 0;
		arst_n = 1'b0;
		// directed: extremes, axes, diagonals, swaps, degenerate
		pending_lines.push_back(make_line(0, 0, 63, 63, 0, 255, 0, 255, 0, 255));
		pending_lines.push_back(make_line(63, 63, 0, 0, 255, 0, 255, 0, 255, 0));
		pending_lines.push_back(make_line(0, 0, 63, 0, 0, 0, 0, 255, 255, 255));
		pending_lines.push_back(make_line(63, 5, 0, 5, 255, 255, 255, 0, 0, 0));
		pending_lines.push_back(make_line(7, 0, 7, 63, 10, 200, 128, 200, 10, 127));
		pending_lines.push_back(make_line(7, 63, 7, 0, 1, 2, 3, 250, 251, 252));
		pending_lines.push_back(make_line(20, 20, 20, 20, 255, 255, 255, 0, 0, 0));
		pending_lines.push_back(make_line(0, 63, 63, 0, 255, 255, 255, 255, 255, 255));
		pending_lines.push_back(make_line(63, 0, 0, 63, 0, 0, 0, 0, 0, 0));
		pending_lines.push_back(make_line(3, 4, 4, 3, 0, 255, 100, 255, 0, 101));
		pending_lines.push_back(make_line(10, 10, 11, 10, 200, 100, 50, 0, 0, 0));
		pending_lines.push_back(make_line(10, 10, 10, 11, 0, 0, 0, 255, 255, 255));
		pending_lines.push_back(make_line(0, 0, 63, 1, 0, 1, 254, 255, 254, 1));
		pending_lines.push_back(make_line(5, 60, 2, 0, 33, 66, 99, 199, 166, 133));
		pending_lines.push_back(make_line(0, 0, 62, 31, 255, 0, 170, 0, 255, 85));
		pending_lines.push_back(make_line(42, 21, 63, 63, 85, 170, 42, 170, 85, 213));
		pending_lines.push_back(make_line(63, 63, 63, 63, 0, 0, 0, 0, 0, 0));
		pending_lines.push_back(make_line(0, 0, 0, 0, 255, 255, 255, 255, 255, 255));
		pending_lines.push_back(make_line(1, 0, 0, 63, 255, 0, 255, 0, 255, 0));
		pending_lines.push_back(make_line(21, 42, 42, 21, 128, 127, 129, 127, 128, 126));
		for (int i = 0; i < 460; i++) pending_lines.push_back(random_line());
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_lines.size() == 0);
		wait (expected_pixels.size() == 0);
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_pixels.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
